/* rtl/core/md5k_pkg.sv */
// Shared types, constants and round functions of the MD5 key digest core.
package md5k_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned BlockWords = BlockBytes / 4;
  localparam int unsigned WordAw     = $clog2(BlockWords);

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_ROUND,
    S_ADD,
    S_DONE
  } state_e;

  // Which message words a compression takes from the block store.
  typedef enum logic [1:0] {
    MODE_FULL,
    MODE_PAD,
    MODE_PADLEN,
    MODE_LEN
  } mode_e;

  function automatic logic [31:0] round_k(input logic [5:0] n);
    logic [31:0] k;
    case (n)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] n);
    logic [4:0] s;
    case ({n[5:4], n[1:0]})
      4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
      4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
      4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
      4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index used by a round.
  function automatic logic [WordAw-1:0] round_g(input logic [5:0] n);
    logic [WordAw-1:0] g;
    case (n[5:4])
      2'd0: g = n[WordAw-1:0];
      2'd1: g = WordAw'(5 * n + 1);
      2'd2: g = WordAw'(3 * n + 5);
      default: g = WordAw'(7 * n);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (r)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

endpackage

/* rtl/core/md5k_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module md5k_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/md5_variant_key_digest_core.sv */
// MD5 key digest core: byte stream in, chaining words and 56-bit key out.
//
// Input stream: one message byte per transfer in s_axis_tdata, with tuser
// marking that the byte is present and tlast closing the message. A transfer
// with tuser low and tlast high closes the message without adding a byte.
// Output stream: one transfer per closed message carrying the four chaining
// words and the key built from digest bytes 0,6,1,5,2,4,3.
// A byte that does not complete a 64-byte block is only stored; a byte that
// completes a block starts a compression (a fetch state, 64 rounds and a
// chaining add), run by the single round unit reading one word a cycle from
// the block RAM, while s_axis_tready stays low. Closing a message costs one
// or two further compressions (two when the padded tail passes byte 55),
// then the result is loaded into the output register.
// Reset clears the chaining words to the MD5 initial values and the byte
// count to zero; the block RAM is not cleared, as only words written by the
// current message are read. The output register holds its transfer while
// the receiver stalls; a new message may stream in meanwhile, but once its
// result is ready the core stalls its input until the register frees up.
module md5_variant_key_digest_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // has_byte
  input  logic         s_axis_tlast,   // message_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] word_a, [63:32] word_b, [95:64] word_c, [127:96] word_d,
  // [183:128] key_bits
  output logic [183:0] m_axis_tdata
);
  import md5k_pkg::*;

  state_e state_q, state_d;
  mode_e  mode_q;
  logic   fin_q;
  logic [5:0]  round_q;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] ch_a_q, ch_b_q, ch_c_q, ch_d_q;
  logic [31:0] cnt_q, cnt_nx;
  logic [31:0] word_q, word_nx;
  logic        out_valid_q, out_valid_d;
  logic [183:0] out_q;

  logic              accept;
  logic              take_byte;
  logic [1:0]        lane;
  logic [WordAw-1:0] wi;
  logic [31:0]       lane_mask;
  logic              ram_we;
  logic [WordAw-1:0] ram_raddr;
  logic [31:0]       ram_rdata;
  logic [WordAw-1:0] g_cur;
  logic [31:0]       msg, pad_word, len_lo, len_hi;
  logic [31:0]       sum, f_val;
  logic [63:0]       rot_wide;
  logic              out_free;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign take_byte = accept && s_axis_tuser;
  assign lane      = cnt_q[1:0];
  assign wi        = cnt_q[WordAw+1:2];
  assign lane_mask = (32'h1 << {lane, 3'b000}) - 32'h1;
  assign word_nx   = (word_q & lane_mask) | (32'(s_axis_tdata) << {lane, 3'b000});
  assign cnt_nx    = cnt_q + 32'(take_byte);
  assign out_free  = !out_valid_q || m_axis_tready;
  // Load on finalisation, otherwise hold until the receiver takes the transfer
  assign out_valid_d = (state_q == S_DONE && out_free) || (out_valid_q && !m_axis_tready);

  md5k_ram #(
    .Width (32),
    .Depth (BlockWords)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wi),
    .wdata_i (word_nx),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Message word for the current round
  assign g_cur    = round_g(round_q);
  assign pad_word = (word_q & lane_mask) | (32'(PadByte) << {lane, 3'b000});
  assign len_lo   = {cnt_q[28:0], 3'b000};
  assign len_hi   = 32'h1 + {3'b000, cnt_q[31:29]};

  always_comb begin
    msg = 32'h0;
    case (mode_q)
      MODE_FULL: msg = ram_rdata;
      MODE_PAD, MODE_PADLEN: begin
        if (g_cur < wi) begin
          msg = ram_rdata;
        end else if (g_cur == wi) begin
          msg = pad_word;
        end else if (mode_q == MODE_PADLEN && g_cur == WordAw'(BlockWords - 2)) begin
          msg = len_lo;
        end else if (mode_q == MODE_PADLEN && g_cur == WordAw'(BlockWords - 1)) begin
          msg = len_hi;
        end
      end
      default: begin
        if (g_cur == WordAw'(BlockWords - 2)) begin
          msg = len_lo;
        end else if (g_cur == WordAw'(BlockWords - 1)) begin
          msg = len_hi;
        end
      end
    endcase
  end

  assign f_val    = round_f(round_q[5:4], b_q, c_q, d_q);
  assign sum      = a_q + f_val + round_k(round_q) + msg;
  assign rot_wide = {sum, sum} << round_s(round_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && ((s_axis_tuser && cnt_q[5:0] == 6'h3f) || s_axis_tlast)) begin
          state_d = S_PRE;
        end
      end
      S_PRE:   state_d = S_ROUND;
      S_ROUND: if (round_q == 6'h3f) state_d = S_ADD;
      S_ADD: begin
        if (mode_q == MODE_PADLEN || mode_q == MODE_LEN) begin
          state_d = S_DONE;
        end else if (mode_q == MODE_FULL && !fin_q) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_PRE;
        end
      end
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    ram_we        = take_byte && (lane == 2'b11);
    ram_raddr     = round_g(round_q + 6'd1);
    if (state_q == S_PRE) begin
      ram_raddr = round_g(6'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_FULL;
      fin_q       <= 1'b0;
      round_q     <= 6'd0;
      cnt_q       <= 32'h0;
      ch_a_q      <= IvA;
      ch_b_q      <= IvB;
      ch_c_q      <= IvC;
      ch_d_q      <= IvD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cnt_q <= cnt_nx;
            fin_q <= s_axis_tlast;
            if (s_axis_tuser && cnt_q[5:0] == 6'h3f) begin
              mode_q <= MODE_FULL;
            end else if (cnt_nx[5:0] >= 6'd56) begin
              mode_q <= MODE_PAD;
            end else begin
              mode_q <= MODE_PADLEN;
            end
          end
        end
        S_PRE: round_q <= 6'd0;
        S_ROUND: round_q <= round_q + 6'd1;
        S_ADD: begin
          ch_a_q <= ch_a_q + a_q;
          ch_b_q <= ch_b_q + b_q;
          ch_c_q <= ch_c_q + c_q;
          ch_d_q <= ch_d_q + d_q;
          if (mode_q == MODE_FULL) begin
            mode_q <= (cnt_q[5:0] >= 6'd56) ? MODE_PAD : MODE_PADLEN;
          end else if (mode_q == MODE_PAD) begin
            mode_q <= MODE_LEN;
          end
        end
        S_DONE: begin
          if (out_free) begin
            fin_q       <= 1'b0;
            cnt_q       <= 32'h0;
            ch_a_q      <= IvA;
            ch_b_q      <= IvB;
            ch_c_q      <= IvC;
            ch_d_q      <= IvD;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (take_byte) begin
      word_q <= word_nx;
    end
    if (state_q == S_PRE) begin
      a_q <= ch_a_q;
      b_q <= ch_b_q;
      c_q <= ch_c_q;
      d_q <= ch_d_q;
    end else if (state_q == S_ROUND) begin
      a_q <= d_q;
      b_q <= b_q + rot_wide[63:32];
      c_q <= b_q;
      d_q <= c_q;
    end
    if (state_q == S_DONE && out_free) begin
      out_q <= {ch_a_q[7:0], ch_b_q[23:16], ch_a_q[15:8], ch_b_q[15:8],
                ch_a_q[23:16], ch_b_q[7:0], ch_a_q[31:24],
                ch_d_q, ch_c_q, ch_b_q, ch_a_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef NO_ASSERTIONS
  a_ram_write_on_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (accept && s_axis_tuser && cnt_q[1:0] == 2'b11))
    else $error("block RAM written outside a word-completing byte");
  a_block_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser && cnt_q[5:0] == 6'h3f) |=> (state_q == S_PRE))
    else $error("full block did not start a compression");
  a_end_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (state_q == S_PRE && fin_q))
    else $error("message end did not start finalisation");
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_q && cnt_q == 32'h0))
    else $error("result not loaded on finalisation");
`endif

endmodule

/* tb/testbench.sv */
// Testbench for the MD5 key digest core: byte stream in, digest words and key checked.
`timescale 1ns / 1ps

class digest_board;
  logic [31:0] chain [4];
  logic [7:0]  blk [64];
  logic [31:0] nbytes;
  logic [183:0] pending [$];
  int errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    chain[0] = md5k_pkg::IvA;
    chain[1] = md5k_pkg::IvB;
    chain[2] = md5k_pkg::IvC;
    chain[3] = md5k_pkg::IvD;
    nbytes = '0;
  endfunction

  function logic [31:0] rotl(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function void compress(logic [31:0] m [16]);
    logic [31:0] a, b, c, d, f, t;
    int g, r;
    int unsigned kt [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    int st [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int n = 0; n < 64; n++) begin
      r = n / 16;
      case (r)
        0: begin f = (b & c) | (~b & d); g = n; end
        1: begin f = (b & d) | (c & ~d); g = (5 * n + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * n + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * n) % 16; end
      endcase
      t = d; d = c; c = b;
      b = b + rotl(a + f + kt[n] + m[g], st[r * 4 + n % 4]);
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endfunction

  function void pack_words(output logic [31:0] m [16]);
    for (int k = 0; k < 16; k++)
      m[k] = {blk[4 * k + 3], blk[4 * k + 2], blk[4 * k + 1], blk[4 * k]};
  endfunction

  // Note an accepted input transfer; queue a digest when it closes a message.
  function void take_input(logic [7:0] data, logic has_byte, logic msg_end);
    logic [31:0] m [16];
    logic [31:0] lo, hi;
    logic [7:0] db [8];
    int pos;
    if (has_byte) begin
      pos = int'(nbytes[5:0]);
      blk[pos] = data;
      nbytes++;
      if (pos == 63) begin
        pack_words(m);
        compress(m);
      end
    end
    if (!msg_end) return;
    lo = nbytes << 3;
    hi = 32'd1 + (nbytes >> 29);
    pos = int'(nbytes[5:0]);
    blk[pos] = md5k_pkg::PadByte;
    for (int i = pos + 1; i < 64; i++) blk[i] = '0;
    if (pos >= 56) begin
      pack_words(m);
      compress(m);
      for (int i = 0; i < 64; i++) blk[i] = '0;
    end
    pack_words(m);
    m[14] = lo;
    m[15] = hi;
    compress(m);
    for (int i = 0; i < 4; i++) db[i] = chain[0][8 * i +: 8];
    for (int i = 0; i < 4; i++) db[4 + i] = chain[1][8 * i +: 8];
    pending.push_back({db[0], db[6], db[1], db[5], db[2], db[4], db[3],
                       chain[3], chain[2], chain[1], chain[0]});
    restart();
  endfunction

  function void check_digest(logic [183:0] got);
    logic [183:0] want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: digest with none expected: %h", got);
      return;
    end
    want = pending.pop_front();
    for (int f = 0; f < 5; f++) begin
      if ((f < 4 && got[32 * f +: 32] !== want[32 * f +: 32]) ||
          (f == 4 && got[183:128] !== want[183:128])) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: field %0d expected %h got %h", f,
                   f < 4 ? want[32 * f +: 32] : want[183:128],
                   f < 4 ? got[32 * f +: 32] : got[183:128]);
      end
    end
  endfunction
endclass

module testbench;
  import md5k_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [183:0] m_axis_tdata;

  digest_board board = new();
  int idle_cycles = 0;
  bit hold_sink = 1'b0;

  always #5 clk_i = ~clk_i;

  md5_variant_key_digest_core u_top (.*);

  // Note transfers on both sides and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        board.take_input(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        board.check_digest(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  // Receiver: random stalls, and one long hold of its own when asked.
  initial begin
    int g;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end else begin
        g = pick_gap();
        if (g == 0 || $urandom_range(3) == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (g - 1) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send(logic [7:0] data, logic has_byte, logic msg_end, bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= has_byte;
    s_axis_tlast <= msg_end;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_message(int len, bit gaps, bit noise);
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(15) == 0) send(8'($urandom_range(255)), 1'b0, 1'b0, gaps);
      send(8'($urandom_range(255)), 1'b1, i == len - 1, gaps);
    end
    if (len == 0) send(8'($urandom_range(255)), 1'b0, 1'b1, gaps);
  endtask

  task automatic drain();
    idle_input();
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    int len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, gap item, byte and end together, extreme bytes,
    // tails either side of the length field, and a full block.
    send(8'hff, 1'b0, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b0, 1'b0);
    send(8'h00, 1'b1, 1'b1, 1'b0);
    send(8'hff, 1'b1, 1'b0, 1'b0);
    send(8'h00, 1'b0, 1'b0, 1'b0);
    send(8'h55, 1'b1, 1'b1, 1'b0);
    send(8'haa, 1'b1, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b1, 1'b0);
    drain();
    send_message(55, 1'b0, 1'b0);
    send_message(56, 1'b0, 1'b0);
    send_message(63, 1'b1, 1'b0);
    send_message(64, 1'b1, 1'b0);
    send_message(120, 1'b1, 1'b0);
    drain();

    // Block the receiver while messages keep coming in.
    hold_sink = 1'b1;
    for (int i = 0; i < 4; i++) send_message($urandom_range(10), 1'b0, 1'b0);
    drain();

    sent = 0;
    while (sent < 1450) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(200, 50) : $urandom_range(70);
      if ($urandom_range(9) == 0)
        send(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1);
      send_message(len, 1'b1, 1'b1);
      sent += len + 1;
      if ($urandom_range(19) == 0) drain();
    end
    idle_input();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (board.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

/* files.f */
rtl/core/md5k_pkg.sv
rtl/core/md5k_ram.sv
rtl/core/md5_variant_key_digest_core.sv
tb/testbench.sv
